@@ rtl/obpli_pkg.sv @@
package obpli_pkg;

   localparam int PRICE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int PRICE_PORT_BITS = 16;
   localparam int PATH_BITS       = 24;
   localparam int WORD_BITS       = 64;
   localparam int DIGIT_BITS      = 6;
   localparam int REQ_USER_BITS   = 3;
   localparam int RSP_USER_BITS   = 3;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_QUERY,
      OP_POP
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EMPTY,
      ST_OVERFLOW,
      ST_UNDERFLOW
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MID,
      S_LEAF,
      S_BEST,
      S_UPDATE,
      S_DONE
   } state_type;

   // highest set bit for bids, lowest for asks; an empty word answers zero
   function automatic logic [DIGIT_BITS-1:0] pick_bit(input logic [WORD_BITS-1:0] w,
                                                     input logic want_high);
      logic [DIGIT_BITS-1:0] idx;
      idx = '0;
      if (want_high) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) idx = DIGIT_BITS'(i);
         end
      end else begin
         for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) idx = DIGIT_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ rtl/obpli_ram.sv @@
module obpli_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/order_book_price_level_index_core.sv @@
// Price level index for both sides of a book. Each side holds a four-level 64-way
// occupancy bitmap tree and an order count per price, in synchronous memories; the
// top word of each side sits in flip-flops. Add and remove take one memory read, one
// write-back and one output load from accept to result; query walks the tree with the
// three dependent memory reads below the top word, and pop adds the write-back of a
// remove. After reset the block sweeps all memories to zero, stepping through every
// count address, while req_tready stays low. Adding to a full count or removing
// from an empty level is flagged and changes nothing.
module order_book_price_level_index_core #(
   parameter int PRICE_BITS = obpli_pkg::PRICE_BITS_DEF,
   parameter int COUNT_BITS = obpli_pkg::COUNT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [obpli_pkg::PRICE_PORT_BITS-1:0] req_tdata,  // price
   input  logic [obpli_pkg::REQ_USER_BITS-1:0]   req_tuser,  // operation[1:0], side[2]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [obpli_pkg::PRICE_PORT_BITS-1:0] rsp_tdata,  // best_price
   output logic [obpli_pkg::RSP_USER_BITS-1:0]   rsp_tuser   // found[0], status[2:1]
);
   import obpli_pkg::*;

   localparam int CNT_AW  = PRICE_BITS + 1;
   localparam int LEAF_AW = PRICE_BITS - 5;
   localparam int MID_AW  = PRICE_BITS - 11;
   localparam int UPR_AW  = DIGIT_BITS + 1;
   localparam logic [PATH_BITS-1:0] PMASK = PATH_BITS'((33'(1) << PRICE_BITS) - 33'(1));
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   function automatic logic [CNT_AW-1:0] cnt_addr(input logic s, input logic [PATH_BITS-1:0] pw);
      logic [PATH_BITS:0] full;
      full = ({{PATH_BITS{1'b0}}, s} << PRICE_BITS) | {1'b0, pw & PMASK};
      return full[CNT_AW-1:0];
   endfunction

   function automatic logic [LEAF_AW-1:0] leaf_addr(input logic s, input logic [PATH_BITS-1:0] pw);
      logic [PATH_BITS:0] full;
      full = ({{PATH_BITS{1'b0}}, s} << (PRICE_BITS - 6)) | {1'b0, (pw & PMASK) >> 6};
      return full[LEAF_AW-1:0];
   endfunction

   function automatic logic [MID_AW-1:0] mid_addr(input logic s, input logic [PATH_BITS-1:0] pw);
      logic [PATH_BITS:0] full;
      full = ({{PATH_BITS{1'b0}}, s} << (PRICE_BITS - 12)) | {1'b0, (pw & PMASK) >> 12};
      return full[MID_AW-1:0];
   endfunction

   function automatic logic [UPR_AW-1:0] upr_addr(input logic s, input logic [PATH_BITS-1:0] pw);
      logic [PATH_BITS-1:0] m;
      m = pw & PMASK;
      return {s, m[23:18]};
   endfunction

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic                       side_ff, side_in;
   logic [PATH_BITS-1:0]       pw_ff, pw_in;
   logic [PRICE_PORT_BITS-1:0] res_best_ff, res_best_in;
   logic                       res_found_ff, res_found_in;
   status_type                 res_status_ff, res_status_in;
   logic [CNT_AW-1:0]          clr_ff, clr_in;
   logic [WORD_BITS-1:0]       top_ff [2];
   logic [WORD_BITS-1:0]       top_in [2];
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [PRICE_PORT_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_USER_BITS-1:0]   rsp_tuser_ff, rsp_tuser_in;

   logic                  cnt_we, leaf_we, mid_we, upr_we;
   logic [CNT_AW-1:0]     cnt_waddr;
   logic [LEAF_AW-1:0]    leaf_waddr;
   logic [MID_AW-1:0]     mid_waddr;
   logic [UPR_AW-1:0]     upr_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
   logic [WORD_BITS-1:0]  leaf_wdata, mid_wdata, upr_wdata;
   logic [WORD_BITS-1:0]  leaf_rdata, mid_rdata, upr_rdata;

   logic                  req_accept;
   op_type                req_op;
   logic                  req_side;
   logic [WORD_BITS-1:0]  b0, b1, b2, b3;
   logic [WORD_BITS-1:0]  leaf_clr, mid_clr, upr_clr, top_clr, top_cur;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser[1:0]);
   assign req_side   = req_tuser[2];

   assign b0 = WORD_BITS'(1) << pw_ff[5:0];
   assign b1 = WORD_BITS'(1) << pw_ff[11:6];
   assign b2 = WORD_BITS'(1) << pw_ff[17:12];
   assign b3 = WORD_BITS'(1) << pw_ff[23:18];
   assign top_cur  = top_ff[side_ff];
   assign leaf_clr = leaf_rdata & ~b0;
   assign mid_clr  = (leaf_clr == '0) ? (mid_rdata & ~b1) : mid_rdata;
   assign upr_clr  = (leaf_clr == '0 && mid_clr == '0) ? (upr_rdata & ~b2) : upr_rdata;
   assign top_clr  = (leaf_clr == '0 && mid_clr == '0 && upr_clr == '0) ?
                     (top_cur & ~b3) : top_cur;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      side_in       = side_ff;
      pw_in         = pw_ff;
      res_best_in   = res_best_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      clr_in        = clr_ff;
      top_in        = top_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      cnt_we        = 1'b0;
      leaf_we       = 1'b0;
      mid_we        = 1'b0;
      upr_we        = 1'b0;
      cnt_wdata     = '0;
      leaf_wdata    = '0;
      mid_wdata     = '0;
      upr_wdata     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            cnt_we  = 1'b1;
            leaf_we = (clr_ff >> LEAF_AW) == '0;
            mid_we  = (clr_ff >> MID_AW) == '0;
            upr_we  = (clr_ff >> UPR_AW) == '0;
            clr_in  = clr_ff + CNT_AW'(1);
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_op;
               side_in       = req_side;
               res_best_in   = '0;
               res_found_in  = 1'b0;
               res_status_in = ST_OK;
               if (req_op == OP_ADD || req_op == OP_REMOVE) begin
                  pw_in    = PATH_BITS'(req_tdata) & PMASK;
                  state_in = S_UPDATE;
               end else if (top_ff[req_side] == '0) begin
                  res_status_in = ST_EMPTY;
                  state_in      = S_DONE;
               end else begin
                  pw_in    = {pick_bit(top_ff[req_side], !req_side), 18'b0};
                  state_in = S_MID;
               end
            end
         end
         S_MID: begin
            pw_in    = {pw_ff[23:18], pick_bit(upr_rdata, !side_ff), 12'b0};
            state_in = S_LEAF;
         end
         S_LEAF: begin
            pw_in    = {pw_ff[23:12], pick_bit(mid_rdata, !side_ff), 6'b0};
            state_in = S_BEST;
         end
         S_BEST: begin
            pw_in        = {pw_ff[23:6], pick_bit(leaf_rdata, !side_ff)} & PMASK;
            res_best_in  = pw_in[PRICE_PORT_BITS-1:0];
            res_found_in = 1'b1;
            state_in     = (op_ff == OP_POP) ? S_UPDATE : S_DONE;
         end
         S_UPDATE: begin
            state_in = S_DONE;
            if (op_ff == OP_ADD) begin
               if (cnt_rdata == CMAX) begin
                  res_status_in = ST_OVERFLOW;
               end else begin
                  cnt_we          = 1'b1;
                  leaf_we         = 1'b1;
                  mid_we          = 1'b1;
                  upr_we          = 1'b1;
                  cnt_wdata       = cnt_rdata + COUNT_BITS'(1);
                  leaf_wdata      = leaf_rdata | b0;
                  mid_wdata       = mid_rdata | b1;
                  upr_wdata       = upr_rdata | b2;
                  top_in[side_ff] = top_cur | b3;
               end
            end else if (cnt_rdata == '0) begin
               res_status_in = ST_UNDERFLOW;
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = cnt_rdata - COUNT_BITS'(1);
               if (cnt_rdata == COUNT_BITS'(1)) begin
                  leaf_we         = 1'b1;
                  mid_we          = 1'b1;
                  upr_we          = 1'b1;
                  leaf_wdata      = leaf_clr;
                  mid_wdata       = mid_clr;
                  upr_wdata       = upr_clr;
                  top_in[side_ff] = top_clr;
               end
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_best_ff;
               rsp_tuser_in  = {res_status_ff, res_found_ff};
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   assign cnt_waddr  = (state_ff == S_CLEAR) ? clr_ff : cnt_addr(side_ff, pw_ff);
   assign leaf_waddr = (state_ff == S_CLEAR) ? clr_ff[LEAF_AW-1:0] : leaf_addr(side_ff, pw_ff);
   assign mid_waddr  = (state_ff == S_CLEAR) ? clr_ff[MID_AW-1:0] : mid_addr(side_ff, pw_ff);
   assign upr_waddr  = (state_ff == S_CLEAR) ? clr_ff[UPR_AW-1:0] : upr_addr(side_ff, pw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         top_ff[0]     <= '0;
         top_ff[1]     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         top_ff        <= top_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      op_ff         <= op_in;
      side_ff       <= side_in;
      pw_ff         <= pw_in;
      res_best_ff   <= res_best_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   obpli_ram #(.WIDTH(COUNT_BITS), .DEPTH(2 ** CNT_AW)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_addr(side_in, pw_in)),
      .rd_data (cnt_rdata)
   );

   obpli_ram #(.WIDTH(WORD_BITS), .DEPTH(2 ** LEAF_AW)) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (leaf_waddr),
      .wr_data (leaf_wdata),
      .rd_addr (leaf_addr(side_in, pw_in)),
      .rd_data (leaf_rdata)
   );

   obpli_ram #(.WIDTH(WORD_BITS), .DEPTH(2 ** MID_AW)) u_mid_ram (
      .clock   (clock),
      .wr_en   (mid_we),
      .wr_addr (mid_waddr),
      .wr_data (mid_wdata),
      .rd_addr (mid_addr(side_in, pw_in)),
      .rd_data (mid_rdata)
   );

   obpli_ram #(.WIDTH(WORD_BITS), .DEPTH(2 ** UPR_AW)) u_upr_ram (
      .clock   (clock),
      .wr_en   (upr_we),
      .wr_addr (upr_waddr),
      .wr_data (upr_wdata),
      .rd_addr (upr_addr(side_in, pw_in)),
      .rd_data (upr_rdata)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_empty_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] == ST_EMPTY |-> !rsp_tuser[0] && rsp_tdata == '0)
      else $error("empty side beat carries a price or found flag");

   a_found_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] != ST_EMPTY && rsp_tuser[2:1] != ST_OVERFLOW)
      else $error("found flag with an add or empty status");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("second beat taken while one is in progress");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

endmodule

@@ tb/sv/tb_order_book_price_level_index_checker.sv @@
module tb_order_book_price_level_index_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_results,
   output int          result_count
);
   import obpli_pkg::*;

   typedef struct packed {
      logic [15:0] best_price;
      logic        found;
      status_type  status;
   } level_result;

   logic [63:0] leaf_words[2][1024];
   logic [63:0] mid_words[2][16];
   logic [63:0] top_word[2];
   logic [15:0] level_count[2][65536];
   level_result awaited_results[$];

   assign pending_results = awaited_results.size();

   function automatic logic [5:0] highest_bit(logic [63:0] w);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) if (w[i]) r = 6'(i);
      return r;
   endfunction

   function automatic logic [5:0] lowest_bit(logic [63:0] w);
      logic [5:0] r;
      r = '0;
      for (int i = 63; i >= 0; i--) if (w[i]) r = 6'(i);
      return r;
   endfunction

   function automatic logic [5:0] best_bit(logic [63:0] w, logic s);
      return s ? lowest_bit(w) : highest_bit(w);
   endfunction

   function automatic status_type take_order(logic s, logic [15:0] p);
      if (level_count[s][p] == '0) return ST_UNDERFLOW;
      level_count[s][p]--;
      if (level_count[s][p] == '0) begin
         leaf_words[s][p[15:6]][p[5:0]] = 1'b0;
         if (leaf_words[s][p[15:6]] == '0) begin
            mid_words[s][p[15:12]][p[11:6]] = 1'b0;
            if (mid_words[s][p[15:12]] == '0) top_word[s][p[15:12]] = 1'b0;
         end
      end
      return ST_OK;
   endfunction

   function automatic level_result book_step(op_type op, logic s, logic [15:0] p);
      level_result r;
      logic [5:0] t, m, l;
      r = '{best_price: 16'd0, found: 1'b0, status: ST_OK};
      case (op)
         OP_ADD: begin
            if (level_count[s][p] == 16'hFFFF) r.status = ST_OVERFLOW;
            else begin
               level_count[s][p]++;
               leaf_words[s][p[15:6]][p[5:0]] = 1'b1;
               mid_words[s][p[15:12]][p[11:6]] = 1'b1;
               top_word[s][p[15:12]] = 1'b1;
            end
         end
         OP_REMOVE: r.status = take_order(s, p);
         default: begin
            if (top_word[s] == '0) r.status = ST_EMPTY;
            else begin
               t = best_bit(top_word[s], s);
               m = best_bit(mid_words[s][t[3:0]], s);
               l = best_bit(leaf_words[s][{t[3:0], m}], s);
               r.best_price = {t[3:0], m, l};
               r.found = 1'b1;
               if (op == OP_POP) r.status = take_order(s, r.best_price);
            end
         end
      endcase
      return r;
   endfunction

   initial begin
      for (int s = 0; s < 2; s++) begin
         top_word[s] = '0;
         for (int i = 0; i < 1024; i++) leaf_words[s][i] = '0;
         for (int i = 0; i < 16; i++) mid_words[s][i] = '0;
         for (int i = 0; i < 65536; i++) level_count[s][i] = '0;
      end
      fail_count = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      level_result want, got;
      if (!reset && req_tvalid && req_tready)
         awaited_results.push_back(book_step(op_type'(req_tuser[1:0]), req_tuser[2], req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{best_price: rsp_tdata, found: rsp_tuser[0],
                 status: status_type'(rsp_tuser[2:1])};
         result_count++;
         if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = awaited_results.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: price exp %h got %h, found exp %b got %b, status exp %s got %s",
                           want.best_price, got.best_price, want.found, got.found,
                           want.status.name(), got.status.name());
            end
         end
      end
   end
endmodule

@@ tb/sv/tb_order_book_price_level_index_core.sv @@
module tb_order_book_price_level_index_core;
   import obpli_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic [2:0]  req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   int          fail_count, pending_results, result_count;
   int          cycle_count = 0;
   int          sent_count = 0;
   bit          stall_free = 0;
   logic [15:0] hot_prices[8];

   always #6 clock = ~clock;

   order_book_price_level_index_core uut (.*);

   tb_order_book_price_level_index_checker book_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("tb_order_book_price_level_index_core NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_free || ((cycle_count / 97) % 4 == 0)) rsp_tready <= 1'b1;
      else if ((cycle_count / 97) % 4 == 1) rsp_tready <= (cycle_count % 5) != 0;
      else rsp_tready <= $urandom_range(0, 2) != 0;
   end

   task automatic send_beat(op_type op, logic s, logic [15:0] p);
      req_tvalid <= 1'b1;
      req_tuser <= {s, op};
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 1'b0;
      req_tdata <= 16'($urandom);
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      idle_gap(1);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      op_type op;
      logic   s;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 2; i++) begin
         send_beat(OP_QUERY, i[0], 16'hFFFF);
         send_beat(OP_POP, i[0], 16'h0);
         send_beat(OP_REMOVE, i[0], 16'h1234);
         send_beat(OP_ADD, i[0], 16'h0000);
         send_beat(OP_ADD, i[0], 16'hFFFF);
         send_beat(OP_ADD, i[0], 16'hFFFF);
         send_beat(OP_QUERY, i[0], 16'h0);
         send_beat(OP_POP, i[0], 16'h0);
         send_beat(OP_REMOVE, i[0], 16'hFFFF);
         send_beat(OP_QUERY, i[0], 16'h0);
         send_beat(OP_REMOVE, i[0], 16'h0000);
         send_beat(OP_POP, i[0], 16'h0);
      end
      drain();
      sent_count = 0;
      while (sent_count < 1650) begin
         for (int k = 0; k < 8; k++) hot_prices[k] = 16'($urandom);
         hot_prices[1] = hot_prices[0] ^ 16'h0001;
         hot_prices[2] = hot_prices[0] ^ 16'h0040;
         hot_prices[3] = hot_prices[0] ^ 16'h1000;
         for (int b = 0; b < 60; b++) begin
            op = op_type'($urandom_range(0, 3));
            s = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) send_beat(op, s, 16'($urandom));
            else send_beat(op, s, hot_prices[3'($urandom_range(0, 7))]);
            if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 8));
         end
         if ($urandom_range(0, 3) == 0) begin
            stall_free = 1'($urandom_range(0, 1));
            drain();
         end
      end
      drain();
      repeat (20) @(posedge clock);
      $display("ran empty-side and empty-level cases on both sides and %0d random beats;",
               sent_count);
      $display("%0d results checked over both sides", result_count);
      if (fail_count == 0 && pending_results == 0)
         $display("tb_order_book_price_level_index_core OK");
      else
         $display("tb_order_book_price_level_index_core NOT OK");
      $finish;
   end
endmodule
